// ===== hw/rtl/simtd_pkg.sv =====
// Shared types and constants for the SIMT divergence mask stack.
package simtd_pkg;

    localparam int CMD_W   = 2;
    localparam int WARP_W  = 4;
    localparam int TC_W    = 6;
    localparam int LANE_W  = 32;
    localparam int LEVEL_W = 4;
    localparam int CNT_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_INIT   = 2'd1,
        CMD_BRANCH = 2'd2,
        CMD_JOIN   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [WARP_W-1:0] warp_id;
        logic [TC_W-1:0]   thread_count;
        logic [LANE_W-1:0] branch_conditions;
    } t_cmd_item;

    typedef struct packed {
        logic [LANE_W-1:0]  active_mask;
        logic               pending_divergence;
        logic [LEVEL_W-1:0] stack_level;
        logic               diverged;
        logic               stack_overflow;
        logic [CNT_W-1:0]   divergence_total;
        logic [CNT_W-1:0]   wasted_total;
    } t_res_item;

endpackage

// ===== hw/rtl/simtd_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transfer.
interface simtd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/simt_divergence_mask_stack_core.sv =====
// Per-warp active mask control with a reconvergence stack of masked-off thread sets.
// Path: a command passes through the execute stage, then the result register.
// Throughput: one command per cycle while results drain; the stack memory read for a command
// is issued as it transfers in, so back-to-back commands on the same warp run without a bubble.
// Reset: masks, thread counts, stack pointers and both counters clear at once;
// the stack memory is not cleared, and a read from it is used only below a stack pointer.
module simt_divergence_mask_stack_core #(
    parameter int NUM_WARPS   = 16,
    parameter int WARP_WIDTH  = 32,
    parameter int STACK_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    simtd_stream_if.sink     i_cmd,
    simtd_stream_if.source   o_res
);

    // Index widths. A warp index and a stack slot together address the stack memory.
    localparam int WIDX      = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
    localparam int WCNT      = 1 << WIDX;
    localparam int SLW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    localparam int SPX       = (SPW > simtd_pkg::LEVEL_W) ? SPW : simtd_pkg::LEVEL_W;
    localparam int AW        = WIDX + SLW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int WEXT      = WIDX + simtd_pkg::WARP_W;
    localparam int TC_W      = simtd_pkg::TC_W;

    // ---------------------------------------------------------------------------------
    // Per-warp state in flops, cleared by reset. Stack entries live in a memory.
    // ---------------------------------------------------------------------------------
    logic [WARP_WIDTH-1:0] r_mask [WCNT];
    logic [TC_W-1:0]       r_thr  [WCNT];
    logic [SPW-1:0]        r_sp   [WCNT];
    logic [WARP_WIDTH-1:0] r_stack [MEM_DEPTH];
    logic [simtd_pkg::CNT_W-1:0] r_div_cnt;
    logic [simtd_pkg::CNT_W-1:0] r_waste_cnt;

    // Execute stage: the command plus the stack pointer and stack top seen for it.
    logic                  r_valid;
    simtd_pkg::t_cmd       r_cmd;
    logic [WIDX-1:0]       r_idx;
    logic                  r_range;
    logic [TC_W-1:0]       r_tc;
    logic [WARP_WIDTH-1:0] r_cond;
    logic [SPW-1:0]        r_sp_in;
    logic [WARP_WIDTH-1:0] r_rd_data;
    logic                  r_fwd;
    logic [WARP_WIDTH-1:0] r_fwd_data;

    // Result register.
    logic                  r_out_valid;
    simtd_pkg::t_res_item  r_res;

    // Handshake. The execute stage commits its state update only when the result
    // register is free or being drained in the same cycle.
    logic adv;
    logic accept;

    assign adv         = r_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_valid || adv;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // Decode the incoming warp id. Out-of-range warps touch no state.
    logic [WEXT-1:0] in_wext;
    logic [WIDX-1:0] in_idx;
    logic            in_range;

    assign in_wext  = {{WIDX{1'b0}}, i_cmd.data.warp_id};
    assign in_idx   = in_wext[WIDX-1:0];
    assign in_range = in_wext < WEXT'(NUM_WARPS);

    // ---------------------------------------------------------------------------------
    // Execute: all bitwise work on one command, plus a popcount and two counter adds.
    // ---------------------------------------------------------------------------------
    logic [WARP_WIDTH-1:0]        cur_mask;
    logic [TC_W-1:0]              cur_thr;
    logic [WARP_WIDTH-1:0]        act;
    logic [WARP_WIDTH-1:0]        fall;
    logic [WARP_WIDTH-1:0]        jump;
    logic [WARP_WIDTH-1:0]        stack_top;
    logic                         full;
    logic [WARP_WIDTH-1:0]        n_mask;
    logic [TC_W-1:0]              n_thr;
    logic [SPW-1:0]               n_sp;
    logic                         push_req;
    logic                         div_hit;
    logic                         ovf;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [simtd_pkg::CNT_W-1:0]  n_div_cnt;
    logic [simtd_pkg::CNT_W-1:0]  n_waste_cnt;

    assign cur_mask  = r_mask[r_idx];
    assign cur_thr   = r_thr[r_idx];
    assign stack_top = r_fwd ? r_fwd_data : r_rd_data;
    assign full      = (r_sp_in == SPW'(STACK_DEPTH));

    always_comb begin
        logic [WARP_WIDTH-1:0] thr_lanes;
        logic [WARP_WIDTH-1:0] init_lanes;
        logic [TC_W-1:0]       tc_sat;

        // Saturate the init thread count at the warp width.
        tc_sat = (r_tc > TC_W'(WARP_WIDTH)) ? TC_W'(WARP_WIDTH) : r_tc;
        for (int i = 0; i < WARP_WIDTH; i++) begin
            thr_lanes[i]  = (cur_thr > TC_W'(i));
            init_lanes[i] = (tc_sat > TC_W'(i));
        end

        act  = cur_mask & thr_lanes;
        fall = act & r_cond;
        jump = act & ~r_cond;

        n_mask   = cur_mask;
        n_thr    = cur_thr;
        n_sp     = r_sp_in;
        push_req = 1'b0;
        div_hit  = 1'b0;

        unique case (r_cmd)
            simtd_pkg::CMD_QUERY: begin
            end
            simtd_pkg::CMD_INIT: begin
                // Init leaves the warp's stack alone.
                n_thr  = tc_sat;
                n_mask = init_lanes;
            end
            simtd_pkg::CMD_BRANCH: begin
                priority if (fall != '0 && jump != '0) begin
                    push_req = 1'b1;
                    n_mask   = fall;
                    div_hit  = 1'b1;
                end else if (jump != '0) begin
                    // Every active thread jumps: park them all.
                    push_req = 1'b1;
                    n_mask   = '0;
                end else begin
                    n_mask = fall;
                end
            end
            simtd_pkg::CMD_JOIN: begin
                // Drop a join on an empty stack.
                if (r_sp_in != '0) begin
                    n_sp   = r_sp_in - SPW'(1);
                    n_mask = cur_mask | stack_top;
                end
            end
            default: begin
            end
        endcase

        // A push onto a full stack is lost; mask and counters still advance.
        ovf = push_req && full;
        if (push_req && !full) begin
            n_sp = r_sp_in + SPW'(1);
        end

        n_div_cnt   = r_div_cnt + simtd_pkg::CNT_W'(div_hit);
        n_waste_cnt = r_waste_cnt
                    + (div_hit ? simtd_pkg::CNT_W'($countones(jump)) : '0);
    end

    assign wr_en   = adv && r_range && push_req && !full;
    assign wr_addr = {r_idx, r_sp_in[SLW-1:0]};

    // Stack pointer of the incoming warp as it stands once the command in the execute
    // stage has committed; the stack read for a join targets the slot below it.
    logic [SPW-1:0] fwd_sp;
    logic [SPW-1:0] rd_slot_full;
    logic [AW-1:0]  rd_addr;

    assign fwd_sp       = (r_valid && r_range && r_idx == in_idx) ? n_sp : r_sp[in_idx];
    assign rd_slot_full = fwd_sp - SPW'(1);
    assign rd_addr      = {in_idx, rd_slot_full[SLW-1:0]};

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= jump;
        end
        if (accept) begin
            r_rd_data <= r_stack[rd_addr];
        end
    end

    // Execute stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (adv) begin
            r_valid <= 1'b0;
        end
    end

    // Execute stage payload; capture a same-cycle write to the slot being read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_cmd.data.command;
            r_idx      <= in_idx;
            r_range    <= in_range;
            r_tc       <= i_cmd.data.thread_count;
            r_cond     <= i_cmd.data.branch_conditions[WARP_WIDTH-1:0];
            r_sp_in    <= fwd_sp;
            r_fwd      <= wr_en && (wr_addr == rd_addr);
            r_fwd_data <= jump;
        end
    end

    // Per-warp state and counters commit as the command moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WCNT; w++) begin
                r_mask[w] <= '0;
                r_thr[w]  <= '0;
                r_sp[w]   <= '0;
            end
            r_div_cnt   <= '0;
            r_waste_cnt <= '0;
        end else if (adv && r_range) begin
            r_mask[r_idx] <= n_mask;
            r_thr[r_idx]  <= n_thr;
            r_sp[r_idx]   <= n_sp;
            r_div_cnt     <= n_div_cnt;
            r_waste_cnt   <= n_waste_cnt;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Out-of-range warps report a blank status with the current counters.
    always_ff @(posedge i_clk) begin
        logic [SPX-1:0] sp_ext;
        sp_ext = SPX'(n_sp);
        if (adv) begin
            if (r_range) begin
                r_res.active_mask        <= simtd_pkg::LANE_W'(n_mask);
                r_res.pending_divergence <= (n_sp != '0);
                r_res.stack_level        <= sp_ext[simtd_pkg::LEVEL_W-1:0];
                r_res.diverged           <= div_hit;
                r_res.stack_overflow     <= ovf;
                r_res.divergence_total   <= n_div_cnt;
                r_res.wasted_total       <= n_waste_cnt;
            end else begin
                r_res.active_mask        <= '0;
                r_res.pending_divergence <= 1'b0;
                r_res.stack_level        <= '0;
                r_res.diverged           <= 1'b0;
                r_res.stack_overflow     <= 1'b0;
                r_res.divergence_total   <= r_div_cnt;
                r_res.wasted_total       <= r_waste_cnt;
            end
        end
    end

`ifndef SYNTHESIS
    // A dropped push leaves the stack exactly full.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.stack_overflow
        |-> o_res.data.stack_level == simtd_pkg::LEVEL_W'(STACK_DEPTH))
        else $error("overflow reported below full stack");

    // A real divergence always leaves something on the stack.
    a_div_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.diverged |-> o_res.data.pending_divergence)
        else $error("divergence without pending stack entry");

    // The stack memory is written only by a committing command.
    a_wr_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> adv && r_valid)
        else $error("stack write without commit");

    // The counters move only as a command commits.
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_div_cnt) && $stable(r_waste_cnt))
        else $error("counter changed without commit");
`endif

endmodule

// ===== tb/simtd_status_checker.sv =====
// Checker for the SIMT divergence mask stack: predicts each warp status and compares results.
module simtd_status_checker #(
    parameter int STACK_SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  logic                 i_cmd_ready,
    input  simtd_pkg::t_cmd_item i_cmd_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  simtd_pkg::t_res_item i_res_data,
    output int                   o_fail_count,
    output int                   o_outstanding
);

    localparam int WARP_W  = simtd_pkg::WARP_W;
    localparam int TC_W    = simtd_pkg::TC_W;
    localparam int LANE_W  = simtd_pkg::LANE_W;
    localparam int LEVEL_W = simtd_pkg::LEVEL_W;
    localparam int CNT_W   = simtd_pkg::CNT_W;
    localparam int WARPS   = 1 << WARP_W;

    logic [LANE_W-1:0]    live_mask  [WARPS];
    logic [TC_W-1:0]      thread_num [WARPS];
    logic [LANE_W-1:0]    reconv_mem [WARPS][STACK_SLOTS];
    int unsigned          depth      [WARPS];
    logic [CNT_W-1:0]     div_events;
    logic [CNT_W-1:0]     idle_slots;
    simtd_pkg::t_res_item expected_status[$];
    int                   fails = 0;
    int                   pending = 0;

    assign o_fail_count  = fails;
    assign o_outstanding = pending;

    function automatic logic [LANE_W-1:0] lanes_below(logic [TC_W-1:0] n);
        logic [LANE_W:0] t;
        t = ({{LANE_W{1'b0}}, 1'b1} << n) - 1'b1;
        return t[LANE_W-1:0];
    endfunction

    // Apply one command to the shadow state and return the status it produces.
    function automatic simtd_pkg::t_res_item warp_step(simtd_pkg::t_cmd_item c);
        simtd_pkg::t_res_item r;
        int                   w;
        logic [TC_W-1:0]      tc;
        logic [LANE_W-1:0]    live;
        logic [LANE_W-1:0]    fall;
        logic [LANE_W-1:0]    jump;
        r = '0;
        w = int'(c.warp_id);
        case (c.command)
            simtd_pkg::CMD_INIT: begin
                tc = (c.thread_count > LANE_W) ? TC_W'(LANE_W) : c.thread_count;
                thread_num[w] = tc;
                live_mask[w]  = lanes_below(tc);
            end
            simtd_pkg::CMD_BRANCH: begin
                live = live_mask[w] & lanes_below(thread_num[w]);
                fall = live & c.branch_conditions;
                jump = live & ~c.branch_conditions;
                if (jump != '0) begin
                    // push the jumping set; drop it when the stack is full
                    if (depth[w] >= STACK_SLOTS) begin
                        r.stack_overflow = 1'b1;
                    end else begin
                        reconv_mem[w][depth[w]] = jump;
                        depth[w]++;
                    end
                    if (fall != '0) begin
                        div_events++;
                        idle_slots += CNT_W'($countones(jump));
                        r.diverged = 1'b1;
                    end
                end
                live_mask[w] = fall;
            end
            simtd_pkg::CMD_JOIN: begin
                if (depth[w] != 0) begin
                    depth[w]--;
                    live_mask[w] |= reconv_mem[w][depth[w]];
                end
            end
            default: ;
        endcase
        r.active_mask        = live_mask[w];
        r.pending_divergence = (depth[w] != 0);
        r.stack_level        = LEVEL_W'(depth[w]);
        r.divergence_total   = div_events;
        r.wasted_total       = idle_slots;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        simtd_pkg::t_res_item want;
        if (!i_rst_n) begin
            for (int w = 0; w < WARPS; w++) begin
                live_mask[w]  = '0;
                thread_num[w] = '0;
                depth[w]      = 0;
            end
            div_events = '0;
            idle_slots = '0;
            expected_status.delete();
        end else begin
            // Check the result transfer first; a command never answers at its own edge.
            if (i_res_valid && i_res_ready) begin
                if (expected_status.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fails++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("active_mask", want.active_mask, i_res_data.active_mask);
                    check_field("pending_divergence", 32'(want.pending_divergence),
                                32'(i_res_data.pending_divergence));
                    check_field("stack_level", 32'(want.stack_level),
                                32'(i_res_data.stack_level));
                    check_field("diverged", 32'(want.diverged), 32'(i_res_data.diverged));
                    check_field("stack_overflow", 32'(want.stack_overflow),
                                32'(i_res_data.stack_overflow));
                    check_field("divergence_total", want.divergence_total,
                                i_res_data.divergence_total);
                    check_field("wasted_total", want.wasted_total, i_res_data.wasted_total);
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                expected_status.push_back(warp_step(i_cmd_data));
            end
        end
        pending = expected_status.size();
    end

endmodule

// ===== tb/tb_simt_divergence_mask_stack_core.sv =====
// Testbench top for the SIMT divergence mask stack: stimulus, back-pressure and verdict.
module tb_simt_divergence_mask_stack_core;

    localparam int WARP_W = simtd_pkg::WARP_W;
    localparam int TC_W   = simtd_pkg::TC_W;
    localparam int LANE_W = simtd_pkg::LANE_W;

    logic i_clk;
    logic i_rst_n;
    bit   steady;        // high during the stretch where neither side idles
    int   fail_count;
    int   outstanding;

    simtd_stream_if #(.T(simtd_pkg::t_cmd_item)) cmd_ch ();
    simtd_stream_if #(.T(simtd_pkg::t_res_item)) res_ch ();

    simt_divergence_mask_stack_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    simtd_status_checker status_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_ch.valid),
        .i_cmd_ready   (cmd_ch.ready),
        .i_cmd_data    (cmd_ch.data),
        .i_res_valid   (res_ch.valid),
        .i_res_ready   (res_ch.ready),
        .i_res_data    (res_ch.data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Bound the run well beyond the slowest correct stall pattern.
    initial begin
        #400000;
        $display("FAIL simt_divergence_mask_stack_core");
        $finish;
    end

    // Stall the result side about 29 times in a hundred, except in the steady stretch.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= steady || ($urandom_range(99) >= 29);
        end
    end

    // Hold one command on the channel until it transfers; insert random gaps first.
    // Enter and leave at a falling edge.
    task automatic send_cmd(simtd_pkg::t_cmd op, int warp, logic [TC_W-1:0] tc,
                            logic [LANE_W-1:0] cond);
        simtd_pkg::t_cmd_item it;
        it.command           = op;
        it.warp_id           = WARP_W'(warp);
        it.thread_count      = tc;
        it.branch_conditions = cond;
        while (!steady && $urandom_range(99) < 29) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every outstanding result to drain.
    task automatic drain;
        cmd_ch.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [LANE_W-1:0] pick_conditions();
        case ($urandom_range(5))
            0:       return '1;
            1:       return '0;
            2:       return ~(LANE_W'(1) << $urandom_range(LANE_W - 1));
            3:       return LANE_W'(1) << $urandom_range(LANE_W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TC_W-1:0] pick_threads();
        case ($urandom_range(9))
            0:       return '0;
            1:       return TC_W'($urandom_range(33, 63));
            2:       return TC_W'(LANE_W);
            default: return TC_W'($urandom_range(1, 32));
        endcase
    endfunction

    initial begin : stimulus
        int              pick;
        int              warp;
        simtd_pkg::t_cmd op;

        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        steady       = 1'b0;
        i_rst_n      = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes, every command and each corner case.
        send_cmd(simtd_pkg::CMD_QUERY,  0,  '0, '0);      // untouched warp
        send_cmd(simtd_pkg::CMD_INIT,   1,  '0, '1);      // zero threads
        send_cmd(simtd_pkg::CMD_BRANCH, 1,  '0, '1);      // no thread active
        send_cmd(simtd_pkg::CMD_JOIN,   1,  '1, '0);      // join with an empty stack
        send_cmd(simtd_pkg::CMD_INIT,   2,  6'd63, '0);   // count saturates to the warp width
        send_cmd(simtd_pkg::CMD_INIT,   2,  6'd33, '0);
        send_cmd(simtd_pkg::CMD_INIT,   3,  6'd1, '0);
        send_cmd(simtd_pkg::CMD_BRANCH, 3,  '0, '0);      // every thread jumps
        send_cmd(simtd_pkg::CMD_JOIN,   3,  '0, '0);      // restore the jumping set
        send_cmd(simtd_pkg::CMD_INIT,   4,  6'd32, '0);
        send_cmd(simtd_pkg::CMD_BRANCH, 4,  '0, '1);      // every thread falls through
        // Peel one thread off per branch so the ninth push finds the stack full.
        send_cmd(simtd_pkg::CMD_INIT,   5,  6'd32, '0);
        for (int i = 0; i < 9; i++) begin
            send_cmd(simtd_pkg::CMD_BRANCH, 5, '0, ~(LANE_W'(1) << i));
        end
        send_cmd(simtd_pkg::CMD_JOIN,   5,  '0, '0);
        send_cmd(simtd_pkg::CMD_INIT,   5,  6'd31, '0);   // init leaves the stack alone
        send_cmd(simtd_pkg::CMD_QUERY,  15, '1, '1);

        // Random part: mostly branches and joins on a few warps so stacks grow deep.
        for (int n = 0; n < 1600; n++) begin
            steady = (n >= 400 && n < 700);
            if (n == 1000) drain();
            pick = $urandom_range(99);
            if (pick < 10)      op = simtd_pkg::CMD_INIT;
            else if (pick < 50) op = simtd_pkg::CMD_BRANCH;
            else if (pick < 85) op = simtd_pkg::CMD_JOIN;
            else                op = simtd_pkg::CMD_QUERY;
            warp = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(15);
            send_cmd(op, warp, pick_threads(), pick_conditions());
        end
        steady = 1'b0;

        drain();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS simt_divergence_mask_stack_core");
        end else begin
            $display("FAIL simt_divergence_mask_stack_core");
        end
        $finish;
    end

endmodule
